// ===== src/frri_pkg.sv =====
// package with the constants, codes and types of the frame relay request interceptor
package frri_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned MAX_RES  = 3;
   localparam int unsigned RES_CNT_W = $clog2(MAX_RES + 1);
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_ADDR_W = 3;

   localparam logic [BYTE_W-1:0] FRAME_REQ_LEN = 8'h03;
   localparam logic [BYTE_W-1:0] MIN_FRAME_LEN = 8'd2;

   localparam logic [BYTE_W-1:0] OPCODE_RESET   = 8'h90;
   localparam logic [BYTE_W-1:0] CHECKSUM_RESET = 8'h93;

   // register index, taken from paddr bit 2
   typedef enum logic {
      REG_OPCODE   = 1'b0,
      REG_CHECKSUM = 1'b1
   } csr_index_type;

   typedef enum logic {
      KIND_FORWARD = 1'b0,
      KIND_REQUEST = 1'b1
   } kind_type;

endpackage

// ===== src/frame_relay_request_interceptor.sv =====
// top level of the frame relay request interceptor: input register, frame logic, result queue
// Host bytes enter on req_ one per handshake and land in an input register; from there one
// pass of logic updates the frame state and loads up to three results into a small result
// queue, which rsp_ drains one item per cycle while rsp_tready is high. A body thus streams
// at one byte per clock while rsp_tready stays high; an item that releases a held pair or a
// failed request frame loads two or three results into the queue, and the next item leaves
// the input register only once the queue is down to its last entry being taken. The input
// register accepts one more item while results still wait. Registers: 0x0 request opcode,
// 0x4 request checksum; write them only while no item is in flight.
module frame_relay_request_interceptor
   import frri_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // host byte in
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [BYTE_W-1:0]       req_tdata,    // [7:0] host_byte
   // results out
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [BYTE_W-1:0]       rsp_tdata,    // [7:0] board_byte
   output logic                    rsp_tuser,    // [0] kind
   output logic                    rsp_tlast,
   // configuration
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [CSR_DATA_W-1:0]   csr_pwdata,
   output logic [CSR_DATA_W-1:0]   csr_prdata,
   output logic                    csr_pready
);

   logic [BYTE_W-1:0]    opcode_ff;
   logic [BYTE_W-1:0]    checksum_ff;

   logic                 in_valid_ff;
   logic [BYTE_W-1:0]    in_byte_ff;

   logic [BYTE_W-1:0]    held0_ff, held0_in;
   logic [BYTE_W-1:0]    held1_ff, held1_in;
   logic [1:0]           held_count_ff, held_count_in;
   logic [BYTE_W-1:0]    body_left_ff, body_left_in;

   logic [BYTE_W-1:0]    out_byte_ff [MAX_RES];
   logic [BYTE_W-1:0]    out_byte_in [MAX_RES];
   logic                 out_kind_ff, out_kind_in;
   logic [RES_CNT_W-1:0] out_cnt_ff, out_cnt_in;

   logic [RES_CNT_W-1:0] res_cnt;
   logic [BYTE_W-1:0]    res_byte [MAX_RES];
   kind_type             res_kind;

   logic                 pop;
   logic                 advance;
   logic                 csr_write;
   csr_index_type        csr_index;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_index_type'(csr_paddr[2]);

   always_comb begin
      unique case (csr_index)
         REG_OPCODE:   csr_prdata = {{(CSR_DATA_W-BYTE_W){1'b0}}, opcode_ff};
         REG_CHECKSUM: csr_prdata = {{(CSR_DATA_W-BYTE_W){1'b0}}, checksum_ff};
         default:      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         opcode_ff   <= OPCODE_RESET;
         checksum_ff <= CHECKSUM_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_OPCODE:   opcode_ff   <= csr_pwdata[BYTE_W-1:0];
            REG_CHECKSUM: checksum_ff <= csr_pwdata[BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   // handshakes
   assign pop        = rsp_tvalid & rsp_tready;
   assign advance    = in_valid_ff &
                       ((out_cnt_ff == '0) || ((out_cnt_ff == RES_CNT_W'(1)) && rsp_tready));
   assign req_tready = ~in_valid_ff | advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   // frame logic for the item in the input register
   always_comb begin
      held0_in      = held0_ff;
      held1_in      = held1_ff;
      held_count_in = held_count_ff;
      body_left_in  = body_left_ff;
      res_cnt       = '0;
      res_kind      = KIND_FORWARD;
      for (int i = 0; i < MAX_RES; i++) begin
         res_byte[i] = '0;
      end

      if (body_left_ff != '0) begin
         body_left_in = body_left_ff - BYTE_W'(1);
         res_cnt      = RES_CNT_W'(1);
         res_byte[0]  = in_byte_ff;
      end else if (held_count_ff >= 2'd2) begin
         // third byte of a candidate request frame
         held_count_in = 2'd0;
         if (in_byte_ff == checksum_ff) begin
            res_cnt  = RES_CNT_W'(1);
            res_kind = KIND_REQUEST;
         end else begin
            res_cnt     = RES_CNT_W'(3);
            res_byte[0] = held0_ff;
            res_byte[1] = held1_ff;
            res_byte[2] = in_byte_ff;
         end
      end else if (held_count_ff == 2'd0) begin
         if (in_byte_ff < MIN_FRAME_LEN) begin
            res_cnt     = RES_CNT_W'(1);
            res_byte[0] = in_byte_ff;
         end else begin
            held0_in      = in_byte_ff;
            held_count_in = 2'd1;
         end
      end else begin
         held1_in = in_byte_ff;
         if (held0_ff == FRAME_REQ_LEN && in_byte_ff == opcode_ff) begin
            held_count_in = 2'd2;
         end else begin
            held_count_in = 2'd0;
            // held0 is at least the minimum length here
            body_left_in  = held0_ff - MIN_FRAME_LEN;
            res_cnt       = RES_CNT_W'(2);
            res_byte[0]   = held0_ff;
            res_byte[1]   = in_byte_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= 2'd0;
         body_left_ff  <= '0;
      end else if (advance) begin
         held_count_ff <= held_count_in;
         body_left_ff  <= body_left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         held0_ff <= held0_in;
         held1_ff <= held1_in;
      end
   end

   // result queue, head in entry 0
   always_comb begin
      out_cnt_in  = out_cnt_ff;
      out_kind_in = out_kind_ff;
      for (int i = 0; i < MAX_RES; i++) begin
         out_byte_in[i] = out_byte_ff[i];
      end
      if (advance) begin
         out_cnt_in  = res_cnt;
         out_kind_in = res_kind;
         for (int i = 0; i < MAX_RES; i++) begin
            out_byte_in[i] = res_byte[i];
         end
      end else if (pop) begin
         out_cnt_in  = out_cnt_ff - RES_CNT_W'(1);
         out_kind_in = KIND_FORWARD;
         for (int i = 0; i < MAX_RES - 1; i++) begin
            out_byte_in[i] = out_byte_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_cnt_ff  <= '0;
         out_kind_ff <= KIND_FORWARD;
      end else begin
         out_cnt_ff  <= out_cnt_in;
         out_kind_ff <= out_kind_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RES; i++) begin
         out_byte_ff[i] <= out_byte_in[i];
      end
   end

   assign rsp_tvalid = (out_cnt_ff != '0);
   assign rsp_tdata  = out_byte_ff[0];
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = (out_cnt_ff == RES_CNT_W'(1));

   // checks
   a_request_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && rsp_tdata == '0)
      else $error("request result not a lone zero item");

   a_no_body_while_held: assert property (@(posedge clock) disable iff (reset)
      held_count_ff != 2'd0 |-> body_left_ff == '0)
      else $error("frame body count set while bytes are held");

   a_queue_drained: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_cnt_ff == $past(res_cnt))
      else $error("result queue overwritten before drained");

endmodule

// ===== dv/frame_relay_request_interceptor_test.sv =====
// testbench for the frame relay request interceptor: directed frames, random traffic, stalls
`timescale 1ns / 100ps

module frame_relay_request_interceptor_test;
   import frri_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE_TICKS = 12;

   typedef struct packed {
      logic [BYTE_W-1:0] board;
      kind_type          kind;
      logic              last;
   } relay_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [BYTE_W-1:0]     req_tdata = '0;      // [7:0] host_byte
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [BYTE_W-1:0]     rsp_tdata;           // [7:0] board_byte
   logic                  rsp_tuser;           // [0] kind
   logic                  rsp_tlast;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // predictor state
   logic [BYTE_W-1:0] cfg_opcode = OPCODE_RESET;
   logic [BYTE_W-1:0] cfg_checksum = CHECKSUM_RESET;
   logic [BYTE_W-1:0] held_len = '0;
   logic [BYTE_W-1:0] held_op = '0;
   logic [1:0]        held_count = '0;
   logic [BYTE_W-1:0] body_left = '0;
   relay_result_type  board_results_due[$];

   int  fail_count = 0;
   int  cycle_count = 0;
   int  sent_count = 0;
   int  tx_burst_left = 0;
   bit  tx_gaps_on = 1'b0;
   bit  rx_stall_on = 1'b0;
   int  rx_run_left = 0;
   bit  rx_ready_phase = 1'b1;
   int  holdoff_left = 0;

   frame_relay_request_interceptor dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic void flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
      fail_count++;
      if (fail_count <= 10)
         $display("mismatch in %s: expected %h, got %h (cycle %0d)", what, want, got,
                  cycle_count);
   endfunction

   function automatic void queue_result(logic [BYTE_W-1:0] b, kind_type k, logic l);
      relay_result_type r;
      r.board = b;
      r.kind  = k;
      r.last  = l;
      board_results_due.push_back(r);
   endfunction

   // frame state machine of the block, one host byte at a time
   function automatic void relay_host_byte(logic [BYTE_W-1:0] b);
      if (body_left != 0) begin
         body_left = body_left - 1'b1;
         queue_result(b, KIND_FORWARD, 1'b1);
      end else if (held_count >= 2'd2) begin
         held_count = 2'd0;
         if (b == cfg_checksum) begin
            queue_result('0, KIND_REQUEST, 1'b1);
         end else begin
            queue_result(held_len, KIND_FORWARD, 1'b0);
            queue_result(held_op, KIND_FORWARD, 1'b0);
            queue_result(b, KIND_FORWARD, 1'b1);
         end
      end else if (held_count == 2'd0) begin
         if (b < MIN_FRAME_LEN) begin
            queue_result(b, KIND_FORWARD, 1'b1);
         end else begin
            held_len   = b;
            held_count = 2'd1;
         end
      end else begin
         held_op = b;
         if (held_len == FRAME_REQ_LEN && held_op == cfg_opcode) begin
            held_count = 2'd2;
         end else begin
            held_count = 2'd0;
            body_left  = held_len - MIN_FRAME_LEN;
            queue_result(held_len, KIND_FORWARD, 1'b0);
            queue_result(held_op, KIND_FORWARD, 1'b1);
         end
      end
   endfunction

   // result checker; prediction runs after the check so a stray result never eats a fresh one
   always @(posedge clock) begin
      relay_result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (board_results_due.size() == 0) begin
               flag_mismatch("unexpected result", '0, 32'({rsp_tdata, rsp_tuser, rsp_tlast}));
            end else begin
               want = board_results_due.pop_front();
               if (rsp_tdata !== want.board)
                  flag_mismatch("board_byte", 32'(want.board), 32'(rsp_tdata));
               if (rsp_tuser !== want.kind)
                  flag_mismatch("kind", 32'(want.kind), 32'(rsp_tuser));
               if (rsp_tlast !== want.last)
                  flag_mismatch("last", 32'(want.last), 32'(rsp_tlast));
            end
         end
         if (req_tvalid && req_tready)
            relay_host_byte(req_tdata);
      end
   end

   // receiver: long hold-off when asked, else random ready/stall runs or always ready
   always @(negedge clock) begin
      if (holdoff_left != 0) begin
         holdoff_left = holdoff_left - 1;
         rsp_tready <= 1'b0;
      end else if (!rx_stall_on) begin
         rsp_tready <= 1'b1;
      end else begin
         if (rx_run_left == 0) begin
            rx_ready_phase = !rx_ready_phase;
            rx_run_left = rx_ready_phase ? $urandom_range(1, 12) : $urandom_range(1, 6);
         end else begin
            rx_run_left--;
         end
         rsp_tready <= rx_ready_phase;
      end
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_host_byte(input logic [BYTE_W-1:0] value);
      int gap;
      req_tdata  <= value;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sent_count++;
      @(negedge clock);
      if (tx_gaps_on) begin
         if (tx_burst_left == 0) begin
            tx_burst_left = $urandom_range(1, 16);
            gap = $urandom_range(1, 8);
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end else begin
            tx_burst_left--;
         end
      end
   endtask

   task automatic wait_until_idle();
      req_tvalid <= 1'b0;
      while (board_results_due.size() != 0) @(negedge clock);
      // a held byte has no result, so give the block time to take it
      repeat (SETTLE_TICKS) @(negedge clock);
   endtask

   task automatic set_idling(input bit gaps, input bit stalls, input int holdoff);
      @(posedge clock);
      tx_gaps_on  = gaps;
      rx_stall_on = stalls;
      holdoff_left = holdoff;
      @(negedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [BYTE_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (idx == REG_OPCODE)
         cfg_opcode = value;
      else
         cfg_checksum = value;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic csr_check(input csr_index_type idx);
      logic [BYTE_W-1:0] want;
      want = (idx == REG_OPCODE) ? cfg_opcode : cfg_checksum;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[BYTE_W-1:0] !== want)
         flag_mismatch("register readback", 32'(want), csr_prdata);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // mostly well-formed frames with random content, some broken ones and noise
   task automatic send_random_frame();
      int pick;
      int roll;
      int len;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         roll = $urandom_range(0, 99);
         len = (roll < 70) ? $urandom_range(2, 10) :
               (roll < 96) ? $urandom_range(11, 40) : $urandom_range(41, 255);
         send_host_byte(BYTE_W'(len));
         send_host_byte(BYTE_W'($urandom));
         for (int i = 2; i < len; i++)
            send_host_byte(BYTE_W'($urandom));
      end else if (pick < 60) begin
         send_host_byte(FRAME_REQ_LEN);
         send_host_byte(cfg_opcode);
         send_host_byte(cfg_checksum);
      end else if (pick < 70) begin
         send_host_byte(FRAME_REQ_LEN);
         send_host_byte(cfg_opcode);
         send_host_byte(BYTE_W'($urandom));
      end else if (pick < 80) begin
         send_host_byte(BYTE_W'($urandom_range(0, 1)));
      end else begin
         repeat ($urandom_range(1, 4)) send_host_byte(BYTE_W'($urandom));
      end
   endtask

   task automatic run_traffic_phase(input logic [BYTE_W-1:0] opcode,
                                    input logic [BYTE_W-1:0] checksum,
                                    input bit gaps, input bit stalls, input int n_items);
      int first;
      wait_until_idle();
      csr_write(REG_OPCODE, opcode);
      csr_write(REG_CHECKSUM, checksum);
      set_idling(gaps, stalls, 0);
      first = sent_count;
      while (sent_count - first < n_items)
         send_random_frame();
      wait_until_idle();
   endtask

   task automatic test_register_access();
      csr_check(REG_OPCODE);
      csr_check(REG_CHECKSUM);
      csr_write(REG_OPCODE, 8'hFF);
      csr_write(REG_CHECKSUM, 8'h00);
      csr_check(REG_OPCODE);
      csr_check(REG_CHECKSUM);
      csr_write(REG_OPCODE, OPCODE_RESET);
      csr_write(REG_CHECKSUM, CHECKSUM_RESET);
      csr_check(REG_OPCODE);
      csr_check(REG_CHECKSUM);
   endtask

   task automatic test_directed_frames();
      set_idling(1'b0, 1'b0, 0);
      // lengths below two pass straight through
      send_host_byte(8'h00);
      send_host_byte(8'h01);
      // bare header, empty body
      send_host_byte(8'h02);
      send_host_byte(8'hFF);
      // header plus two body bytes
      send_host_byte(8'h04);
      send_host_byte(8'h00);
      send_host_byte(8'hAA);
      send_host_byte(8'hFF);
      // local request swallowed, then one with a bad checksum
      send_host_byte(FRAME_REQ_LEN);
      send_host_byte(OPCODE_RESET);
      send_host_byte(CHECKSUM_RESET);
      send_host_byte(FRAME_REQ_LEN);
      send_host_byte(OPCODE_RESET);
      send_host_byte(8'h00);
      // length three with another opcode is an ordinary frame with one body byte
      send_host_byte(FRAME_REQ_LEN);
      send_host_byte(8'h55);
      send_host_byte(OPCODE_RESET);
      // opcode changed while the checksum is awaited: only the checksum decides
      send_host_byte(FRAME_REQ_LEN);
      send_host_byte(OPCODE_RESET);
      wait_until_idle();
      csr_write(REG_OPCODE, 8'h21);
      send_host_byte(CHECKSUM_RESET);
      wait_until_idle();
      csr_write(REG_OPCODE, OPCODE_RESET);
      // checksum changed while waiting: held pair released with the third byte
      send_host_byte(FRAME_REQ_LEN);
      send_host_byte(OPCODE_RESET);
      wait_until_idle();
      csr_write(REG_CHECKSUM, 8'h10);
      send_host_byte(CHECKSUM_RESET);
      wait_until_idle();
      csr_write(REG_CHECKSUM, CHECKSUM_RESET);
   endtask

   task automatic test_random_traffic();
      run_traffic_phase(8'h00, 8'hFF, 1'b0, 1'b0, 90);
      run_traffic_phase(8'hFF, 8'h00, 1'b1, 1'b1, 90);
      run_traffic_phase(BYTE_W'($urandom), BYTE_W'($urandom), 1'b1, 1'b0, 90);
      run_traffic_phase(OPCODE_RESET, CHECKSUM_RESET, 1'b0, 1'b1, 90);
   endtask

   // receiver holds off while the sender keeps offering, so the input side backs up
   task automatic test_backpressure();
      int first;
      wait_until_idle();
      set_idling(1'b0, 1'b0, 400);
      first = sent_count;
      while (sent_count - first < 60)
         send_random_frame();
      wait_until_idle();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_register_access();
      test_directed_frames();
      test_random_traffic();
      test_backpressure();
      wait_until_idle();
      if (fail_count == 0 && board_results_due.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
